// ----- rtl/line_rasterizer_macros.svh -----
// ----------------------------------------------------------------------------
// line_rasterizer_macros
// Assertion macros used by the line rasterizer top level.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRAST_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("line_rasterizer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LRAST_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("line_rasterizer: next-cycle check failed");

// Expression must hold at every clock edge out of reset.
`define LRAST_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("line_rasterizer: invariant failed");

`endif

// ----- rtl/lrast_pkg.sv -----
// ----------------------------------------------------------------------------
// lrast_pkg
// Widths, constants and shared types of the line rasterizer.
// ----------------------------------------------------------------------------
package lrast_pkg;

    localparam int COORD_W    = 6;
    localparam int DIM_W      = 7;
    localparam int COLOR_W    = 24;
    localparam int ADDR_W     = 12;
    localparam int ERR_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    localparam logic [DIM_W-1:0] CANVAS_MAX = DIM_W'(64);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic load;  // take a new segment into the walker
        logic emit;  // write current pixel to the output word and step
    } cmd_t;

    typedef struct packed {
        logic last;      // current pixel is the final one of the segment
        logic out_free;  // output word register can take a new pixel
    } status_t;

endpackage

// ----- rtl/lrast_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrast_ctrl
// Controller: accepts a segment, then drives one Bresenham step per free
// output slot until the last pixel has been issued.
// ----------------------------------------------------------------------------
module lrast_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lrast_pkg::status_t status,
    output lrast_pkg::cmd_t    cmd
);

    lrast_pkg::state_t state_reg;
    lrast_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrast_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lrast_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = lrast_pkg::ST_WALK;
                end
            end
            lrast_pkg::ST_WALK: begin
                if (status.out_free && status.last) begin
                    state_next = lrast_pkg::ST_IDLE;
                end
            end
            default: state_next = lrast_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            lrast_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            lrast_pkg::ST_WALK: begin
                cmd.emit = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/lrast_dp.sv -----
// ----------------------------------------------------------------------------
// lrast_dp
// Datapath: segment setup, Bresenham walker, canvas registers and the
// output word register with address and clipping.
// ----------------------------------------------------------------------------
module lrast_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // s_tdata: start_x, start_y, end_x, end_y, line_color (lowest bit up)
    input  logic [lrast_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic                                   cfg_we,
    input  logic [lrast_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [lrast_pkg::DIM_W-1:0]            cfg_wdata,
    input  lrast_pkg::cmd_t                        cmd,
    output lrast_pkg::status_t                     status,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // m_tdata: pixel_x, pixel_y, pixel_address, pixel_color (lowest bit up)
    output logic [lrast_pkg::M_TDATA_W-1:0]        m_tdata,
    // m_tuser: write_enable
    output logic                                   m_tuser,
    output logic                                   m_tlast
);

    localparam int CW = lrast_pkg::COORD_W;
    localparam int DW = lrast_pkg::DIM_W;
    localparam int EW = lrast_pkg::ERR_W;
    localparam int AW = lrast_pkg::ADDR_W;

    // Input word fields
    logic [CW-1:0] x0, y0, x1, y1;
    logic [lrast_pkg::COLOR_W-1:0] in_color;

    assign x0       = s_tdata[CW-1:0];
    assign y0       = s_tdata[2*CW-1:CW];
    assign x1       = s_tdata[3*CW-1:2*CW];
    assign y1       = s_tdata[4*CW-1:3*CW];
    assign in_color = s_tdata[4*CW+lrast_pkg::COLOR_W-1:4*CW];

    // Canvas registers
    logic [DW-1:0] width_reg, height_reg;
    logic [DW-1:0] w_eff, h_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lrast_pkg::CANVAS_MAX;
            height_reg <= lrast_pkg::CANVAS_MAX;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                lrast_pkg::CFG_CANVAS_WIDTH:  width_reg  <= cfg_wdata;
                lrast_pkg::CFG_CANVAS_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_eff = (width_reg  > lrast_pkg::CANVAS_MAX) ? lrast_pkg::CANVAS_MAX : width_reg;
    assign h_eff = (height_reg > lrast_pkg::CANVAS_MAX) ? lrast_pkg::CANVAS_MAX : height_reg;

    // Segment setup
    logic [CW-1:0] adx, ady, dmajor, dminor, sx0, sy0, sx1, sy1;
    logic          major_y, swap, minor_neg;
    logic [EW-1:0] err_init;

    always_comb begin
        adx       = (x1 > x0) ? (x1 - x0) : (x0 - x1);
        ady       = (y1 > y0) ? (y1 - y0) : (y0 - y1);
        major_y   = !(ady < adx);
        swap      = major_y ? (y0 > y1) : (x0 > x1);
        sx0       = swap ? x1 : x0;
        sy0       = swap ? y1 : y0;
        sx1       = swap ? x0 : x1;
        sy1       = swap ? y0 : y1;
        dmajor    = major_y ? ady : adx;
        dminor    = major_y ? adx : ady;
        minor_neg = major_y ? (sx1 < sx0) : (sy1 < sy0);
        err_init  = {(EW-CW-1)'(0), dminor, 1'b0} - EW'(dmajor);
    end

    // Walker state
    logic [CW-1:0] walk_x_reg, walk_y_reg, steps_left_reg, dmajor_reg, dminor_reg;
    logic [EW-1:0] err_reg;
    logic          minor_neg_reg, major_y_reg, force_off_reg;
    logic [lrast_pkg::COLOR_W-1:0] color_reg;

    logic          minor_move;
    logic [EW-1:0] err_next;
    logic [CW-1:0] minor_coord, minor_coord_next, walk_x_next, walk_y_next;

    always_comb begin
        minor_move  = !err_reg[EW-1] && (err_reg != '0);
        if (minor_move) begin
            err_next = err_reg + {(EW-CW-1)'(0), dminor_reg, 1'b0}
                               - {(EW-CW-1)'(0), dmajor_reg, 1'b0};
        end else begin
            err_next = err_reg + {(EW-CW-1)'(0), dminor_reg, 1'b0};
        end
        minor_coord      = major_y_reg ? walk_x_reg : walk_y_reg;
        minor_coord_next = minor_coord;
        if (minor_move) begin
            minor_coord_next = minor_neg_reg ? (minor_coord - 1'b1) : (minor_coord + 1'b1);
        end
        if (major_y_reg) begin
            walk_y_next = walk_y_reg + 1'b1;
            walk_x_next = minor_coord_next;
        end else begin
            walk_x_next = walk_x_reg + 1'b1;
            walk_y_next = minor_coord_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            walk_x_reg     <= sx0;
            walk_y_reg     <= sy0;
            err_reg        <= err_init;
            dmajor_reg     <= dmajor;
            dminor_reg     <= dminor;
            minor_neg_reg  <= minor_neg;
            major_y_reg    <= major_y;
            color_reg      <= in_color;
            // zero-length segment: one pixel, never written
            force_off_reg  <= (dmajor == '0);
            steps_left_reg <= (dmajor == '0) ? CW'(1) : dmajor;
        end else if (cmd.emit) begin
            walk_x_reg     <= walk_x_next;
            walk_y_reg     <= walk_y_next;
            err_reg        <= err_next;
            steps_left_reg <= steps_left_reg - 1'b1;
        end
    end

    // Pixel address and clipping
    logic [AW:0]   prod;
    logic [AW-1:0] pix_addr;
    logic          in_canvas;

    always_comb begin
        prod      = (AW+1)'(walk_y_reg) * (AW+1)'(w_eff);
        pix_addr  = AW'(prod + (AW+1)'(walk_x_reg));
        in_canvas = ({1'b0, walk_x_reg} < w_eff) && ({1'b0, walk_y_reg} < h_eff)
                    && !force_off_reg;
    end

    // Output word register
    logic                          m_tvalid_reg;
    logic [lrast_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                          m_tuser_reg, m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {color_reg, pix_addr, walk_y_reg, walk_x_reg};
            m_tuser_reg <= in_canvas;
            m_tlast_reg <= (steps_left_reg == CW'(1));
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign status.last     = (steps_left_reg == CW'(1));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- rtl/line_rasterizer.sv -----
// An accepted segment loads the walker; in the walk state the first pixel word
// then enters the output register once it is free. Throughput: one pixel per
// cycle from the Bresenham step unit while the output is not stalled; the next
// segment is taken the cycle after its last pixel enters the output register.
// Output stalls hold the walker. Reset (aresetn low, synchronous) clears the
// controller and the output valid and sets both canvas registers to 64.
// ----------------------------------------------------------------------------
// line_rasterizer
// Streams the pixels of one line segment per input word, with frame address,
// canvas clipping and last flag.
// ----------------------------------------------------------------------------
`include "line_rasterizer_macros.svh"

module line_rasterizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18],
    //          line_color[47:24]
    input  logic [lrast_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: pixel_x[5:0], pixel_y[11:6], pixel_address[23:12],
    //          pixel_color[47:24]
    output logic [lrast_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: write_enable
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [lrast_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [lrast_pkg::DIM_W-1:0]       cfg_wdata
);

    lrast_pkg::cmd_t    cmd;
    lrast_pkg::status_t status;

    lrast_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lrast_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // a taken segment starts a walk: no second word until it is done
    `LRAST_ASSERT_NEXT(a_load_starts_walk, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // issuing the final pixel returns the controller to accept
    `LRAST_ASSERT_NEXT(a_last_ends_walk, aclk, aresetn, cmd.emit && status.last, s_tready)
    // a pixel is issued only while walking, and then into a free slot
    `LRAST_ASSERT_IMPLIES(a_emit_in_walk, aclk, aresetn, cmd.emit, !s_tready && status.out_free)
    `LRAST_ASSERT_ALWAYS(a_cmd_exclusive, aclk, aresetn, $onehot0({cmd.load, cmd.emit}))

endmodule
